@@ rtl/core/lis_pkg.sv @@
// ----------------------------------------------------------------------------
// lis_pkg - shared types and constants
// Payload structs for both channels, the chain control group and the default
// sizes handed to the longest increasing subsequence unit.
// ----------------------------------------------------------------------------
package lis_pkg;

    localparam int unsigned CAPACITY_DEF    = 1024;
    localparam int unsigned VALUE_WIDTH_DEF = 32;
    localparam int unsigned IN_VALUE_W      = 32;
    localparam int unsigned LEN_W           = 11;

    typedef struct packed {
        logic signed [IN_VALUE_W-1:0] value;
        logic                         first_of_sequence;
    } item_t;

    typedef struct packed {
        logic [LEN_W-1:0] ending_length;
        logic [LEN_W-1:0] best_length;
        logic             overflow;
    } result_t;

    // Control group carried by a transaction as it walks the chain.
    typedef struct packed {
        logic valid;   // stage holds a transaction
        logic first;   // transaction opens a new sequence
        logic done;    // transaction has already claimed a cell
    } chain_ctrl_t;

endpackage

@@ rtl/core/lis_cell.sv @@
// ----------------------------------------------------------------------------
// lis_cell - one tail cell of the chain
// Holds the smallest tail for one subsequence length and passes each
// transaction on to its neighbour through its own output registers.
// ----------------------------------------------------------------------------
module lis_cell #(
    parameter int unsigned VALUE_WIDTH = lis_pkg::VALUE_WIDTH_DEF,
    parameter int unsigned COUNT_W     = lis_pkg::LEN_W
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  lis_pkg::chain_ctrl_t       in_ctrl,
    input  logic [VALUE_WIDTH-1:0]     in_key,
    input  logic [COUNT_W-1:0]         in_count,
    input  logic [COUNT_W-1:0]         in_ending,
    output lis_pkg::chain_ctrl_t       out_ctrl,
    output logic [VALUE_WIDTH-1:0]     out_key,
    output logic [COUNT_W-1:0]         out_count,
    output logic [COUNT_W-1:0]         out_ending
);

    logic [VALUE_WIDTH-1:0] tail_reg, tail_next;
    logic                   tail_valid_reg, tail_valid_next;
    lis_pkg::chain_ctrl_t   ctrl_reg, ctrl_next;
    logic [VALUE_WIDTH-1:0] key_reg;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [COUNT_W-1:0]     ending_reg, ending_next;
    logic                   live;
    logic                   hit;

    always_comb
    begin
        // A new sequence drops the stored tail before the compare.
        live = tail_valid_reg && !in_ctrl.first;
        hit  = in_ctrl.valid && !in_ctrl.done
               && (!live || ($signed(tail_reg) >= $signed(in_key)));

        tail_next       = hit ? in_key : tail_reg;
        tail_valid_next = in_ctrl.valid ? (live || hit) : tail_valid_reg;

        ctrl_next      = in_ctrl;
        ctrl_next.done = in_ctrl.done || hit;
        count_next     = in_count + COUNT_W'(live || hit);
        ending_next    = hit ? (in_count + COUNT_W'(1)) : in_ending;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_valid_reg <= 1'b0;
            ctrl_reg       <= '0;
        end
        else if (advance)
        begin
            tail_valid_reg <= tail_valid_next;
            ctrl_reg       <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tail_reg   <= tail_next;
            key_reg    <= in_key;
            count_reg  <= count_next;
            ending_reg <= ending_next;
        end
    end

    assign out_ctrl   = ctrl_reg;
    assign out_key    = key_reg;
    assign out_count  = count_reg;
    assign out_ending = ending_reg;

endmodule

@@ rtl/core/longest_increasing_subsequence_unit.sv @@
// ----------------------------------------------------------------------------
// longest_increasing_subsequence_unit - systolic patience-tails tracker
// Keeps the smallest tail of every strictly increasing subsequence length in
// a row of cells and reports, per value, the length ending there, the best
// length so far and an overflow flag.
// ----------------------------------------------------------------------------
//
//  channel   signals                          payload    direction
//  item      item_valid / item_ready          item_t     into the unit
//  result    result_valid / result_ready      result_t   out of the unit
//
//  Flow: one transaction enters per cycle while the chain advances; each item
//  passes one register per cell on its walk through the CAPACITY cells, then
//  the result register, before result_valid rises.
//  Reset: rst_n clears every cell's valid flag and all stage valids; no
//  clearing pass is needed.
//  Stalls: the whole chain advances together; a held result freezes it and
//  item_ready drops until result_ready takes the result.
//
module longest_increasing_subsequence_unit #(
    parameter int unsigned CAPACITY    = lis_pkg::CAPACITY_DEF,
    parameter int unsigned VALUE_WIDTH = lis_pkg::VALUE_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  lis_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_ready,
    output lis_pkg::result_t  result
);

    // Wide enough to count every cell of the row.
    localparam int unsigned COUNT_W = $clog2(CAPACITY + 1);

    lis_pkg::chain_ctrl_t   chain_ctrl   [0:CAPACITY];
    logic [VALUE_WIDTH-1:0] chain_key    [0:CAPACITY];
    logic [COUNT_W-1:0]     chain_count  [0:CAPACITY];
    logic [COUNT_W-1:0]     chain_ending [0:CAPACITY];

    logic                   advance;
    logic [VALUE_WIDTH-1:0] entry_key;

    logic                   result_valid_reg, result_valid_next;
    lis_pkg::result_t       result_reg, result_next;

    // Advance the row whenever the output register is free or being taken.
    assign advance    = !result_valid_reg || result_ready;
    assign item_ready = advance;

    // Take the low VALUE_WIDTH bits as the signed key; zero-extend if wider.
    generate
        if (VALUE_WIDTH <= lis_pkg::IN_VALUE_W)
        begin : g_key_narrow
            assign entry_key = item.value[VALUE_WIDTH-1:0];
        end
        else
        begin : g_key_wide
            assign entry_key = {{(VALUE_WIDTH - lis_pkg::IN_VALUE_W){1'b0}}, item.value};
        end
    endgenerate

    // Head of the chain: a fresh transaction has claimed nothing yet.
    always_comb
    begin
        chain_ctrl[0].valid = item_valid && item_ready;
        chain_ctrl[0].first = item.first_of_sequence;
        chain_ctrl[0].done  = 1'b0;
    end
    assign chain_key[0]    = entry_key;
    assign chain_count[0]  = '0;
    assign chain_ending[0] = '0;

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            lis_cell #(
                .VALUE_WIDTH (VALUE_WIDTH),
                .COUNT_W     (COUNT_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .advance    (advance),
                .in_ctrl    (chain_ctrl[i]),
                .in_key     (chain_key[i]),
                .in_count   (chain_count[i]),
                .in_ending  (chain_ending[i]),
                .out_ctrl   (chain_ctrl[i+1]),
                .out_key    (chain_key[i+1]),
                .out_count  (chain_count[i+1]),
                .out_ending (chain_ending[i+1])
            );
        end
    endgenerate

    // Tail of the chain: a transaction that never claimed a cell overflowed,
    // and the count of live cells it passed is the best length.
    always_comb
    begin
        result_valid_next         = chain_ctrl[CAPACITY].valid;
        result_next.overflow      = !chain_ctrl[CAPACITY].done;
        result_next.ending_length = chain_ctrl[CAPACITY].done
                                    ? lis_pkg::LEN_W'(chain_ending[CAPACITY])
                                    : '0;
        result_next.best_length   = lis_pkg::LEN_W'(chain_count[CAPACITY]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    // Hold the result while it waits for result_ready.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
